// ----- hdl/cme_pkg.sv -----
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, symbol codes and the Russian Morse letter table used by the
// front, the job queue and the serializer of the Cyrillic Morse encoder.
// ----------------------------------------------------------------------------
package cme_pkg;

  // Output symbol codes.
  localparam logic [1:0] SymDot   = 2'd0;
  localparam logic [1:0] SymDash  = 2'd1;
  localparam logic [1:0] SymGap   = 2'd2;
  localparam logic [1:0] SymSlash = 2'd3;

  // Byte classification constants.
  localparam logic [7:0] LeadMin  = 8'h80;
  localparam logic [7:0] CyrLead  = 8'hD0;
  localparam logic [7:0] CyrFirst = 8'h90;
  localparam logic [7:0] CyrLast  = 8'hAF;
  localparam logic [7:0] AsciiSpace = 8'h20;

  // Job geometry: at most five marks plus the trailing gap.
  localparam int unsigned MaxMarks = 5;
  localparam int unsigned MaxSyms  = 6;
  localparam int unsigned CntW     = 3;

  // Default depth of the job queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // One queued job: symbols packed first-out in the low bits and their count.
  typedef struct packed {
    logic [CntW-1:0]        count;
    logic [2*MaxSyms-1:0]   syms;
  } job_t;

  // Letter table entry: mark count and mark pattern, first mark in bit 0,
  // a set bit is a dash.
  typedef struct packed {
    logic [CntW-1:0]     len;
    logic [MaxMarks-1:0] pat;
  } letter_t;

  // Russian Morse code for the capital letters A through YA.
  function automatic letter_t letter_code(input logic [4:0] idx);
    letter_t r;
    unique case (idx)
      5'd0:  r = '{len: 3'd2, pat: 5'b00010};
      5'd1:  r = '{len: 3'd4, pat: 5'b00001};
      5'd2:  r = '{len: 3'd3, pat: 5'b00110};
      5'd3:  r = '{len: 3'd3, pat: 5'b00011};
      5'd4:  r = '{len: 3'd3, pat: 5'b00001};
      5'd5:  r = '{len: 3'd1, pat: 5'b00000};
      5'd6:  r = '{len: 3'd4, pat: 5'b01000};
      5'd7:  r = '{len: 3'd4, pat: 5'b00011};
      5'd8:  r = '{len: 3'd2, pat: 5'b00000};
      5'd9:  r = '{len: 3'd4, pat: 5'b01110};
      5'd10: r = '{len: 3'd3, pat: 5'b00101};
      5'd11: r = '{len: 3'd4, pat: 5'b00010};
      5'd12: r = '{len: 3'd2, pat: 5'b00011};
      5'd13: r = '{len: 3'd2, pat: 5'b00001};
      5'd14: r = '{len: 3'd3, pat: 5'b00111};
      5'd15: r = '{len: 3'd4, pat: 5'b00110};
      5'd16: r = '{len: 3'd3, pat: 5'b00010};
      5'd17: r = '{len: 3'd3, pat: 5'b00000};
      5'd18: r = '{len: 3'd1, pat: 5'b00001};
      5'd19: r = '{len: 3'd3, pat: 5'b00100};
      5'd20: r = '{len: 3'd4, pat: 5'b00100};
      5'd21: r = '{len: 3'd4, pat: 5'b00000};
      5'd22: r = '{len: 3'd4, pat: 5'b00101};
      5'd23: r = '{len: 3'd4, pat: 5'b00111};
      5'd24: r = '{len: 3'd4, pat: 5'b01111};
      5'd25: r = '{len: 3'd4, pat: 5'b01011};
      5'd26: r = '{len: 3'd5, pat: 5'b11011};
      5'd27: r = '{len: 3'd4, pat: 5'b01101};
      5'd28: r = '{len: 3'd4, pat: 5'b01001};
      5'd29: r = '{len: 3'd5, pat: 5'b00100};
      5'd30: r = '{len: 3'd4, pat: 5'b01100};
      5'd31: r = '{len: 3'd4, pat: 5'b01010};
      default: r = '{len: 3'd0, pat: 5'b00000};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/cme_front.sv -----
// ----------------------------------------------------------------------------
// cme_front
// Accepts text bytes, tracks an open two-byte pair and turns each character
// that produces output into a job of symbols for the queue.
// ----------------------------------------------------------------------------
module cme_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      text_byte_i,
  input  logic            start_of_text_i,
  output logic            push_o,
  output cme_pkg::job_t   job_o
);

  logic        lead_pending_q, lead_pending_d;
  logic [7:0]  lead_value_q, lead_value_d;
  logic        pending_eff;
  logic        is_letter;
  logic        is_space;
  cme_pkg::letter_t code;
  logic [cme_pkg::MaxMarks:0] pat_ext;

  // A start flag drops any open pair before the byte is looked at.
  assign pending_eff = lead_pending_q & ~start_of_text_i;

  // Classify the byte against the open pair.
  assign is_letter = pending_eff && (lead_value_q == cme_pkg::CyrLead) &&
                     (text_byte_i >= cme_pkg::CyrFirst) &&
                     (text_byte_i <= cme_pkg::CyrLast);
  assign is_space  = !pending_eff && (text_byte_i == cme_pkg::AsciiSpace);

  assign code    = cme_pkg::letter_code(5'(text_byte_i - cme_pkg::CyrFirst));
  assign pat_ext = {1'b0, code.pat};

  // Build the symbol list of the job.
  always_comb begin
    job_o = '0;
    if (is_letter) begin
      job_o.count = code.len + 3'd1;
      for (int i = 0; i < cme_pkg::MaxSyms; i++) begin
        if (3'(i) < code.len) begin
          job_o.syms[2*i +: 2] = pat_ext[i] ? cme_pkg::SymDash : cme_pkg::SymDot;
        end else begin
          job_o.syms[2*i +: 2] = cme_pkg::SymGap;
        end
      end
    end else begin
      job_o.count     = 3'd2;
      job_o.syms[1:0] = cme_pkg::SymSlash;
      job_o.syms[3:2] = cme_pkg::SymGap;
    end
  end

  assign push_o = accept_i && (is_letter || is_space);

  // Pair state update.
  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_value_d   = lead_value_q;
    if (accept_i) begin
      if (pending_eff) begin
        lead_pending_d = 1'b0;
        lead_value_d   = '0;
      end else if (text_byte_i >= cme_pkg::LeadMin) begin
        lead_pending_d = 1'b1;
        lead_value_d   = text_byte_i;
      end else begin
        lead_pending_d = 1'b0;
        lead_value_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_value_q   <= '0;
    end else begin
      lead_pending_q <= lead_pending_d;
      lead_value_q   <= lead_value_d;
    end
  end

endmodule

// ----- hdl/cme_fifo.sv -----
// ----------------------------------------------------------------------------
// cme_fifo
// Short job queue that decouples the byte front from the symbol serializer.
// ----------------------------------------------------------------------------
module cme_fifo #(
  parameter int unsigned Depth = cme_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cme_pkg::job_t   job_i,
  input  logic            pop_i,
  output cme_pkg::job_t   job_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  cme_pkg::job_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/cme_back.sv -----
// ----------------------------------------------------------------------------
// cme_back
// Symbol serializer: takes one job from the queue and presents its symbols
// one per cycle from an output register unless stalled, marking the final one.
// ----------------------------------------------------------------------------
module cme_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  cme_pkg::job_t   job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      symbol_o,
  output logic            last_o
);

  logic                          busy_q;
  logic [cme_pkg::CntW-1:0]      cnt_q;
  logic [2*cme_pkg::MaxSyms-1:0] syms_q;
  logic                          advance;

  assign advance = busy_q && !out_stall_i;

  // Load the next job when idle or when the final symbol leaves.
  assign pop_o = !empty_i && (!busy_q || (advance && cnt_q == 3'd1));

  assign out_valid_o = busy_q;
  assign symbol_o    = syms_q[1:0];
  assign last_o      = (cnt_q == 3'd1);

  // Symbol shift register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      syms_q <= job_i.syms;
    end else if (advance) begin
      syms_q <= {2'b00, syms_q[2*cme_pkg::MaxSyms-1:2]};
    end
  end

  // Job control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= job_i.count;
    end else if (advance) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 3'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/cyrillic_morse_encoder_core.sv -----
// A closing byte's job is written into the job queue and then loaded into the
// serializer's output register, when the serializer is idle.
// Throughput: one byte per cycle at the input while the job queue has room;
// the serializer emits one symbol per cycle unless stalled, and a letter's job
// has two to six symbols. Sustained rate is set by the serializer.
// Reset clears the open-pair state, the job queue pointers and the output valid.
// ----------------------------------------------------------------------------
// cyrillic_morse_encoder_core
// Encodes a UTF-8 byte stream of capital Cyrillic letters and spaces into
// Russian Morse symbols: byte front, job queue and symbol serializer.
// ----------------------------------------------------------------------------
module cyrillic_morse_encoder_core #(
  parameter int unsigned QueueDepth = cme_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        start_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  symbol_o,
  output logic        last_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  cme_pkg::job_t push_job;
  cme_pkg::job_t head_job;

  // The front takes a request whenever the queue has room for its job.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cme_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .text_byte_i     (text_byte_i),
    .start_of_text_i (start_of_text_i),
    .push_o          (push),
    .job_o           (push_job)
  );

  cme_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  cme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

  // A job pushed into the queue carries between two and six symbols.
  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_job.count >= 3'd2 && push_job.count <= 3'd6))
    else $error("job with an invalid symbol count");

  // A symbol that is not the last of its request is always followed by more.
  a_job_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("symbol job ended without a final symbol");

  // The serializer only loads from a queue that holds a job.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("job loaded from an empty queue");

endmodule

// ----- tb/cyrillic_morse_encoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// cyrillic_morse_encoder_core_tb
// Self-checking bench for the Cyrillic Morse encoder. A byte-level predictor
// tracks the open-pair state and queues the expected Morse symbols for each
// accepted request. Each result is checked against the oldest one in the queue.
// Stimulus is a short set of corner cases and then random text: letters,
// spaces, stray bytes and broken pairs. It runs under several idle and stall
// mixes, one long output hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module cyrillic_morse_encoder_core_tb;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last;
  } sym_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_byte_i;
  logic       start_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] symbol_o;
  logic       last_o;

  // Predictor state: a lead byte waiting for its partner.
  logic       pair_open;
  logic [7:0] pair_lead;

  sym_beat_t  expected_syms[$];
  int         err_count;
  int         bytes_taken;
  int         syms_seen;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_req;

  cyrillic_morse_encoder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .start_of_text_i(start_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Dots and dashes of the capital letters A through YA.
  function automatic string morse_pattern(input logic [4:0] idx);
    case (idx)
      5'd0:  return ".-";
      5'd1:  return "-...";
      5'd2:  return ".--";
      5'd3:  return "--.";
      5'd4:  return "-..";
      5'd5:  return ".";
      5'd6:  return "...-";
      5'd7:  return "--..";
      5'd8:  return "..";
      5'd9:  return ".---";
      5'd10: return "-.-";
      5'd11: return ".-..";
      5'd12: return "--";
      5'd13: return "-.";
      5'd14: return "---";
      5'd15: return ".--.";
      5'd16: return ".-.";
      5'd17: return "...";
      5'd18: return "-";
      5'd19: return "..-";
      5'd20: return "..-.";
      5'd21: return "....";
      5'd22: return "-.-.";
      5'd23: return "---.";
      5'd24: return "----";
      5'd25: return "--.-";
      5'd26: return "--.--";
      5'd27: return "-.--";
      5'd28: return "-..-";
      5'd29: return "..-..";
      5'd30: return "..--";
      default: return ".-.-";
    endcase
  endfunction

  // Work out the symbols one accepted byte causes and queue them.
  task automatic predict_symbols(input logic [7:0] b, input logic sot);
    logic [1:0] syms [6];
    int         n;
    string      code;
    sym_beat_t  beat;
    n = 0;
    if (sot) begin
      pair_open = 1'b0;
      pair_lead = 8'h00;
    end
    if (pair_open) begin
      pair_open = 1'b0;
      if (pair_lead == cme_pkg::CyrLead && b >= cme_pkg::CyrFirst &&
          b <= cme_pkg::CyrLast) begin
        code = morse_pattern(5'(b - cme_pkg::CyrFirst));
        for (int i = 0; i < code.len() && n < 5; i++) begin
          syms[n] = (code[i] == "-") ? cme_pkg::SymDash : cme_pkg::SymDot;
          n++;
        end
        syms[n] = cme_pkg::SymGap;
        n++;
      end
      pair_lead = 8'h00;
    end else if (b >= cme_pkg::LeadMin) begin
      pair_open = 1'b1;
      pair_lead = b;
    end else if (b == cme_pkg::AsciiSpace) begin
      syms[0] = cme_pkg::SymSlash;
      syms[1] = cme_pkg::SymGap;
      n = 2;
    end
    for (int k = 0; k < n; k++) begin
      beat.symbol = syms[k];
      beat.last   = (k == n - 1);
      expected_syms.insert(expected_syms.size(), beat);
    end
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Compare one accepted symbol with the oldest expectation.
  task automatic check_symbol(input logic [1:0] sym, input logic lst);
    sym_beat_t want;
    if (expected_syms.size() == 0) begin
      report_mismatch($sformatf("symbol %0d last %0d with nothing expected", sym, lst));
    end else begin
      want = expected_syms.pop_front();
      if (sym !== want.symbol) begin
        report_mismatch($sformatf("symbol %0d, expected %0d", sym, want.symbol));
      end
      if (lst !== want.last) begin
        report_mismatch($sformatf("last %0d, expected %0d", lst, want.last));
      end
    end
  endtask

  // Offer one request, with random idle cycles ahead of it, until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic sot);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    text_byte_i     <= b;
    start_of_text_i <= sot;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    bytes_taken++;
    predict_symbols(b, sot);
  endtask

  // Two-byte capital letter by table index.
  task automatic send_letter(input logic [4:0] idx, input logic sot);
    send_byte(cme_pkg::CyrLead, sot);
    send_byte(cme_pkg::CyrFirst + 8'(idx), 1'b0);
  endtask

  // Drop valid and wait until every queued symbol has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_syms.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random text: mostly letters and spaces, some stray bytes and broken pairs.
  task automatic send_random_text(input int count);
    int sent;
    int pick;
    logic sot;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      sot  = ($urandom_range(15) == 0);
      if (pick < 55) begin
        send_letter(5'($urandom_range(31)), sot);
        sent += 2;
      end else if (pick < 70) begin
        send_byte(cme_pkg::AsciiSpace, sot);
        sent++;
      end else if (pick < 80) begin
        send_byte(8'($urandom_range(127)), sot);
        sent++;
      end else if (pick < 90) begin
        send_byte(8'($urandom_range(255, 128)), sot);
        send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0));
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(255)), ($urandom_range(1) == 0));
        sent++;
      end
    end
  endtask

  // Corner cases: space, other ASCII, edge letters, out-of-range and foreign
  // pairs, a lead closing a pair, a dropped lead and the five-mark letters.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_byte(cme_pkg::AsciiSpace, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd31, 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b0);
    send_byte(cme_pkg::CyrFirst - 8'd1, 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b0);
    send_byte(cme_pkg::CyrLast + 8'd1, 1'b0);
    send_byte(8'hD1, 1'b0);
    send_byte(cme_pkg::CyrFirst, 1'b0);
    send_byte(cme_pkg::LeadMin, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(cme_pkg::AsciiSpace, 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b0);
    send_byte(cme_pkg::AsciiSpace, 1'b1);
    send_byte(cme_pkg::CyrLead, 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b1);
    send_byte(cme_pkg::CyrFirst, 1'b0);
    send_letter(5'd26, 1'b0);
    send_letter(5'd29, 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b0);
  endtask

  // Random text under one mix of sender idling and receiver stalling.
  task automatic test_random_text(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_random_text(count);
  endtask

  // Long output hold-off while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 300;
    for (int i = 0; i < 12; i++) begin
      send_letter(5'($urandom_range(31)), 1'b0);
    end
  endtask

  // Sender pauses with a pair open until every result is out, then closes it.
  task automatic test_drain_pause();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_letter(5'($urandom_range(31)), 1'b0);
    send_byte(cme_pkg::CyrLead, 1'b0);
    wait_drained();
    send_byte(cme_pkg::CyrFirst + 8'($urandom_range(31)), 1'b0);
    send_random_text(20);
  endtask

  // Receiver: samples outputs mid-cycle, checks at the edge, drives stall.
  initial begin
    logic       o_valid;
    logic [1:0] o_sym;
    logic       o_last;
    logic       o_stall;
    int         hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      o_valid = out_valid_o;
      o_sym   = symbol_o;
      o_last  = last_o;
      o_stall = out_stall_i;
      @(posedge clk_i);
      if (o_valid && !o_stall) begin
        syms_seen++;
        check_symbol(o_sym, o_last);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  initial begin
    int last_progress;
    int quiet;
    last_progress = 0;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if (bytes_taken + syms_seen != last_progress) begin
        last_progress = bytes_taken + syms_seen;
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("cyrillic_morse_encoder_core regression: fail");
        $finish;
      end
    end
  end

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    text_byte_i     = 8'h00;
    start_of_text_i = 1'b0;
    pair_open       = 1'b0;
    pair_lead       = 8'h00;
    err_count       = 0;
    bytes_taken     = 0;
    syms_seen       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_text(0, 0, 50);
    test_random_text(83, 0, 50);
    test_random_text(0, 83, 50);
    test_random_text(21, 21, 50);
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("cyrillic_morse_encoder_core regression: pass");
    end else begin
      $display("cyrillic_morse_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- cyrillic_morse_encoder_core.f -----
hdl/cme_pkg.sv
hdl/cme_front.sv
hdl/cme_fifo.sv
hdl/cme_back.sv
hdl/cyrillic_morse_encoder_core.sv
tb/cyrillic_morse_encoder_core_tb.sv
